### rtl/sed_pkg.sv
// Shared types, constants and helpers for the string escape decoder.
// Used by every module of the block through scoped names; no dependencies.
package sed_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int OUT_COUNT_W = 16;
  localparam int MAX_RES     = 5;
  localparam int RES_CNT_W   = 3;
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_AW     = 1;

  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CODE_BS   = 8'h08;
  localparam logic [7:0] CODE_TAB  = 8'h09;
  localparam logic [7:0] CODE_LF   = 8'h0A;
  localparam logic [7:0] CODE_VT   = 8'h0B;
  localparam logic [7:0] CODE_FF   = 8'h0C;
  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] CODE_NUL  = 8'hFE;
  localparam logic [7:0] CODE_ZERO = 8'h00;
  localparam logic [7:0] CTRL_MASK = 8'h1F;

  typedef enum logic [4:0] {
    MODE_TEXT = 5'b00001,
    MODE_ESC  = 5'b00010,
    MODE_CTRL = 5'b00100,
    MODE_HEX2 = 5'b01000,
    MODE_HEX4 = 5'b10000
  } mode_t;

  // One decoded input: the result bytes it causes, how many, and end of string.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [RES_CNT_W-1:0]    cnt;
    logic                    last;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [OUT_COUNT_W-1:0] to_out_count(logic [COUNT_WIDTH-1:0] c);
    return OUT_COUNT_W'(c);
  endfunction

endpackage

### rtl/string_escape_decoder.sv
// Top level of the string escape decoder: front end, command queue, back end.
// Depends on sed_pkg, sed_front, sed_cmdq and sed_back.
//
// Usage: escaped string bytes enter on in_byte with in_last_byte marking the
// final byte; a transaction is taken when push is high and full is low.
// Decoded bytes leave as a queue: while empty is low the oldest result is on
// out_byte, out_run_last, out_string_end and out_count, and pop takes it.
// The first result of a byte passes through the command queue and then the
// result register before it is visible. Throughput: one input byte per cycle
// while each byte yields at most one result and pop stays high; the results
// of a byte (up to five, on a failed hex escape) enter the result register
// one at a time. A byte that opens an escape yields no result unless it ends the
// string. The two-entry command queue lets input continue while results drain;
// full rises when it fills. If the receiver stalls, results and commands wait and
// full rises once the queue is full; nothing is lost. Reset returns the decoder to
// plain text, clears the count and empties the queue and the result register.
module string_escape_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_string_end,
  output logic [15:0] out_count
);

  sed_pkg::cmd_t cmd, head;
  logic          accept, q_push, head_valid, head_pop;

  assign accept = push && !full;
  assign q_push = accept && (cmd.cnt != '0);

  sed_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .cmd          (cmd)
  );

  sed_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (cmd),
    .q_full     (full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sed_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head),
    .head_pop       (head_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .out_count      (out_count)
  );

endmodule

### rtl/sed_front.sv
// Front end of the string escape decoder: escape state machine that turns one
// input byte into a command holding up to five result bytes. Uses sed_pkg.
module sed_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last_byte,
  output sed_pkg::cmd_t cmd
);

  sed_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     dcnt_r, dcnt_nxt;
  logic [7:0]     acc_r, acc_nxt;
  logic [2:0][7:0] pend_r, pend_nxt;

  sed_pkg::hex_t                  hx;
  logic [sed_pkg::RES_CNT_W-1:0]  n;
  logic [sed_pkg::MAX_RES-1:0][7:0] res;
  logic                           need_done;

  always_comb begin
    mode_nxt  = mode_r;
    dcnt_nxt  = dcnt_r;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    n         = '0;
    res       = '0;
    hx        = sed_pkg::hex_value(in_byte);
    need_done = 1'b0;

    unique case (mode_r)
      sed_pkg::MODE_TEXT: begin
        if (in_byte == sed_pkg::CH_BSL) begin
          mode_nxt = sed_pkg::MODE_ESC;
        end else begin
          res[n] = in_byte; n = n + 1'b1;
        end
      end
      sed_pkg::MODE_ESC: begin
        mode_nxt = sed_pkg::MODE_TEXT;
        unique case (in_byte)
          sed_pkg::CH_DQUOTE, sed_pkg::CH_SQUOTE, sed_pkg::CH_LF, sed_pkg::CH_BSL: begin
            res[n] = in_byte; n = n + 1'b1;
          end
          sed_pkg::CH_NUL: begin res[n] = sed_pkg::CODE_NUL; n = n + 1'b1; end
          sed_pkg::CH_B:   begin res[n] = sed_pkg::CODE_BS;  n = n + 1'b1; end
          sed_pkg::CH_T:   begin res[n] = sed_pkg::CODE_TAB; n = n + 1'b1; end
          sed_pkg::CH_N:   begin res[n] = sed_pkg::CODE_LF;  n = n + 1'b1; end
          sed_pkg::CH_V:   begin res[n] = sed_pkg::CODE_VT;  n = n + 1'b1; end
          sed_pkg::CH_F:   begin res[n] = sed_pkg::CODE_FF;  n = n + 1'b1; end
          sed_pkg::CH_R:   begin res[n] = sed_pkg::CODE_CR;  n = n + 1'b1; end
          sed_pkg::CH_C:   begin mode_nxt = sed_pkg::MODE_CTRL; end
          sed_pkg::CH_X: begin
            mode_nxt = sed_pkg::MODE_HEX2;
            dcnt_nxt = '0;
            acc_nxt  = '0;
          end
          sed_pkg::CH_U: begin
            mode_nxt = sed_pkg::MODE_HEX4;
            dcnt_nxt = '0;
            acc_nxt  = '0;
          end
          default: begin
            res[n] = sed_pkg::CH_BSL; n = n + 1'b1;
            res[n] = in_byte;         n = n + 1'b1;
          end
        endcase
      end
      sed_pkg::MODE_CTRL: begin
        res[n] = in_byte & sed_pkg::CTRL_MASK; n = n + 1'b1;
        mode_nxt = sed_pkg::MODE_TEXT;
      end
      sed_pkg::MODE_HEX2, sed_pkg::MODE_HEX4: begin
        if (!hx.ok) begin
          // Abort: a zero, then held digits and a non-backslash byte as text.
          res[n] = sed_pkg::CODE_ZERO; n = n + 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < dcnt_r) begin
              res[n] = pend_r[i]; n = n + 1'b1;
            end
          end
          dcnt_nxt = '0;
          acc_nxt  = '0;
          if (in_byte == sed_pkg::CH_BSL) begin
            mode_nxt = sed_pkg::MODE_ESC;
          end else begin
            mode_nxt = sed_pkg::MODE_TEXT;
            res[n] = in_byte; n = n + 1'b1;
          end
        end else begin
          acc_nxt   = {acc_r[3:0], hx.val};
          need_done = (mode_r == sed_pkg::MODE_HEX2) ? (dcnt_r == 2'd1) : (dcnt_r == 2'd3);
          if (need_done) begin
            res[n] = acc_nxt; n = n + 1'b1;
            dcnt_nxt = '0;
            acc_nxt  = '0;
            mode_nxt = sed_pkg::MODE_TEXT;
          end else begin
            pend_nxt[dcnt_r] = in_byte;
            dcnt_nxt = dcnt_r + 2'd1;
          end
        end
      end
      default: begin
        mode_nxt = sed_pkg::MODE_TEXT;
      end
    endcase

    // End of string flushes whatever escape is still open.
    if (in_last_byte) begin
      unique case (mode_nxt)
        sed_pkg::MODE_ESC: begin
          res[n] = sed_pkg::CH_BSL; n = n + 1'b1;
        end
        sed_pkg::MODE_CTRL: begin
          res[n] = sed_pkg::CODE_ZERO; n = n + 1'b1;
        end
        sed_pkg::MODE_HEX2, sed_pkg::MODE_HEX4: begin
          res[n] = sed_pkg::CODE_ZERO; n = n + 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < dcnt_nxt) begin
              res[n] = pend_nxt[i]; n = n + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      mode_nxt = sed_pkg::MODE_TEXT;
      dcnt_nxt = '0;
      acc_nxt  = '0;
    end
  end

  assign cmd.bytes = res;
  assign cmd.cnt   = n;
  assign cmd.last  = in_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sed_pkg::MODE_TEXT;
      dcnt_r <= '0;
      acc_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      dcnt_r <= dcnt_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

`ifndef SYNTH
  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |-> cmd.cnt != '0)
    else $error("string end produced no result");
  a_last_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |=> mode_r == sed_pkg::MODE_TEXT && dcnt_r == '0)
    else $error("escape state not cleared after string end");
`endif

endmodule

### rtl/sed_cmdq.sv
// Short command queue between the front and back ends of the escape decoder.
// Register based; depth and command type come from sed_pkg.
module sed_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sed_pkg::cmd_t push_cmd,
  output logic          q_full,
  input  logic          pop,
  output logic          head_valid,
  output sed_pkg::cmd_t head
);

  sed_pkg::cmd_t                 mem_r [sed_pkg::CMDQ_DEPTH];
  logic [sed_pkg::CMDQ_AW-1:0]   wr_r, rd_r;
  logic [sed_pkg::CMDQ_AW:0]     count_r;

  assign q_full     = (count_r == (sed_pkg::CMDQ_AW+1)'(sed_pkg::CMDQ_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> !pop)
    else $error("command queue popped while empty");
`endif

endmodule

### rtl/sed_back.sv
// Back end of the escape decoder (sed_pkg): plays each command out one byte
// per cycle while pop allows into the result register; saturating byte count.
module sed_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  sed_pkg::cmd_t head,
  output logic          head_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          out_run_last,
  output logic          out_string_end,
  output logic [15:0]   out_count
);

  logic [sed_pkg::RES_CNT_W-1:0]   idx_r, idx_nxt;
  logic [sed_pkg::COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                            valid_r;
  logic                            adv, is_final;

  // The result register takes a new byte when it is empty or being drained.
  assign adv      = head_valid && (!valid_r || pop);
  assign is_final = (idx_r == head.cnt - 1'b1);
  assign head_pop = adv && is_final;
  assign empty    = !valid_r;

  always_comb begin
    cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    cnt_nxt = (is_final && head.last) ? '0 : cnt_inc;
    idx_nxt = is_final ? '0 : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      if (adv) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
        cnt_r   <= cnt_nxt;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte       <= head.bytes[idx_r];
      out_run_last   <= is_final;
      out_string_end <= is_final && head.last;
      out_count      <= sed_pkg::to_out_count(cnt_inc);
    end
  end

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r < head.cnt)
    else $error("result index beyond command length");
  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_final && head.last |=> cnt_r == '0)
    else $error("byte count not cleared at string end");
`endif

endmodule
